### sv/imubc_pkg.sv
// ----------------------------------------------------------------------------
// imubc_pkg
// Shared types and constants for the inertial bias calibration block.
// ----------------------------------------------------------------------------
package imubc_pkg;

   localparam int AXES    = 6;
   localparam int AXIS_W  = 3;
   localparam int RAW_W   = 16;
   localparam int SUM_W   = 29;
   localparam int OFF_W   = 17;
   localparam int CORR_W  = 18;
   localparam int CNT_W   = 13;
   localparam int DISC_W  = 6;
   localparam int TMAG_W  = 18;
   localparam int TEMP_W  = 15;
   localparam int MAG_W   = SUM_W - 1;
   localparam int STEP_W  = 5;

   localparam logic [DISC_W-1:0] DISCARD_FRAMES  = 6'd50;
   localparam logic [CNT_W-1:0]  MAX_CAL_SAMPLES = 13'd4096;
   localparam logic [CNT_W-1:0]  CAL_SAMPLES_RST = 13'd200;
   localparam logic signed [OFF_W-1:0]  ACCEL_ONE_G = 17'sd16384;
   localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 15'sd3653;

   // x / 17 == (x * ceil(2^23 / 17)) >> 23, exact for x below 2^20
   localparam logic [18:0] RECIP_17    = 19'd493448;
   localparam int          RECIP_SHIFT = 23;
   localparam int          TPROD_W     = TMAG_W + 19;

   localparam logic [AXIS_W-1:0] AXIS_AZ   = 3'd2;
   localparam logic [AXIS_W-1:0] AXIS_LAST = 3'd5;
   localparam logic [STEP_W-1:0] DIV_LAST  = 5'd27;

   typedef struct packed {
      logic                       start;
      logic [AXES-1:0][RAW_W-1:0] raw;
      logic                       tneg;
      logic [TMAG_W-1:0]          tmag;
   } imubc_item_type;

   typedef struct packed {
      logic                    go;
      logic [SUM_W-1:0]        dividend;
      logic [CNT_W-1:0]        divisor;
   } imubc_div_req_type;

   typedef struct packed {
      logic                    done;
      logic [OFF_W-1:0]        quotient;
   } imubc_div_rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0]  ax;
      logic [OFF_W-1:0]  ay;
      logic [CORR_W-1:0] az;
      logic [OFF_W-1:0]  gx;
      logic [OFF_W-1:0]  gy;
      logic [OFF_W-1:0]  gz;
      logic [TEMP_W-1:0] temp;
      logic              calibrating;
      logic              calibrated;
   } imubc_result_type;

endpackage

### sv/imubc_front.sv
// ----------------------------------------------------------------------------
// imubc_front
// Classifies incoming items and prepares the temperature magnitude.
// ----------------------------------------------------------------------------
module imubc_front (
   input  logic                        req_mode,
   input  logic [imubc_pkg::AXES-1:0][imubc_pkg::RAW_W-1:0] req_raw,
   input  logic [imubc_pkg::RAW_W-1:0] req_temp,
   output imubc_pkg::imubc_item_type   item
);

   logic                         tneg;
   logic [imubc_pkg::RAW_W:0]    tabs;
   logic [imubc_pkg::TMAG_W-1:0] tmag5;

   always_comb begin
      tneg  = req_temp[imubc_pkg::RAW_W-1];
      tabs  = tneg ? (17'd0 - {1'b1, req_temp}) : {1'b0, req_temp};
      // |t| * 5 as shift and add
      tmag5 = imubc_pkg::TMAG_W'({tabs, 2'b00}) + imubc_pkg::TMAG_W'(tabs);
      item.start = req_mode;
      item.raw   = req_raw;
      item.tneg  = tneg;
      item.tmag  = tmag5;
   end

endmodule

### sv/imubc_queue.sv
// ----------------------------------------------------------------------------
// imubc_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
module imubc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  imubc_pkg::imubc_item_type push_item,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output imubc_pkg::imubc_item_type head_item
);

   imubc_pkg::imubc_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full       = (count_ff == 2'd2);
      head_valid = (count_ff != 2'd0);
      head_item  = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/imubc_div.sv
// ----------------------------------------------------------------------------
// imubc_div
// Bit-serial signed divider: sum by frame count, truncating toward zero.
// ----------------------------------------------------------------------------
module imubc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  imubc_pkg::imubc_div_req_type req,
   output imubc_pkg::imubc_div_rsp_type rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          neg_ff, neg_in;
   logic [imubc_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [imubc_pkg::MAG_W-1:0]   work_ff, work_in;
   logic [imubc_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [imubc_pkg::CNT_W-1:0]   dvs_ff, dvs_in;
   logic [imubc_pkg::SUM_W-1:0]   mag;
   logic [imubc_pkg::CNT_W:0]     trial;
   logic [imubc_pkg::CNT_W:0]     diff;
   logic                          ge;
   logic [imubc_pkg::OFF_W-1:0]   qmag;

   always_comb begin
      mag     = req.dividend[imubc_pkg::SUM_W-1] ? (29'd0 - req.dividend) : req.dividend;
      trial   = {rem_ff, work_ff[imubc_pkg::MAG_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.go) begin
         busy_in = 1'b1;
         neg_in  = req.dividend[imubc_pkg::SUM_W-1];
         step_in = '0;
         work_in = mag[imubc_pkg::MAG_W-1:0];
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in  = ge ? diff[imubc_pkg::CNT_W-1:0] : trial[imubc_pkg::CNT_W-1:0];
         work_in = {work_ff[imubc_pkg::MAG_W-2:0], ge};
         step_in = step_ff + 5'd1;
         if (step_ff == imubc_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      qmag         = work_ff[imubc_pkg::OFF_W-1:0];
      rsp.done     = done_ff;
      rsp.quotient = neg_ff ? (17'd0 - qmag) : qmag;
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

### sv/imubc_back.sv
// ----------------------------------------------------------------------------
// imubc_back
// Calibration sequencer, offset correction, temperature scaling, result stage.
// ----------------------------------------------------------------------------
module imubc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [imubc_pkg::CNT_W-1:0]  cal_samples,
   input  logic                         head_valid,
   input  imubc_pkg::imubc_item_type    head_item,
   output logic                         pop,
   output imubc_pkg::imubc_div_req_type div_req,
   input  imubc_pkg::imubc_div_rsp_type div_rsp,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output imubc_pkg::imubc_result_type  rsp_result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [imubc_pkg::AXIS_W-1:0]        axis_ff, axis_in;
   logic [imubc_pkg::SUM_W-1:0]         sums_ff [imubc_pkg::AXES];
   logic [imubc_pkg::SUM_W-1:0]         sums_in [imubc_pkg::AXES];
   logic [imubc_pkg::OFF_W-1:0]         offs_ff [imubc_pkg::AXES];
   logic [imubc_pkg::OFF_W-1:0]         offs_in [imubc_pkg::AXES];
   logic [imubc_pkg::DISC_W-1:0]        disc_ff, disc_in;
   logic [imubc_pkg::CNT_W-1:0]         samp_ff, samp_in;
   logic                                active_ff, active_in;
   logic                                done_ff, done_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   imubc_pkg::imubc_result_type         result_ff, result_in;

   logic                                out_free;
   logic                                load;
   logic                                final_frame;
   logic [imubc_pkg::CNT_W-1:0]         n_eff;
   logic [imubc_pkg::CNT_W:0]           samp_next;
   logic signed [imubc_pkg::CORR_W-1:0] diff [imubc_pkg::AXES];
   logic [imubc_pkg::TPROD_W-1:0]       tprod;
   logic [imubc_pkg::TEMP_W-1:0]        tq;
   logic [imubc_pkg::TEMP_W-1:0]        temp;
   logic [imubc_pkg::OFF_W-1:0]         qfix;

   always_comb begin
      priority if (cal_samples == '0) begin
         n_eff = 13'd1;
      end else if (cal_samples > imubc_pkg::MAX_CAL_SAMPLES) begin
         n_eff = imubc_pkg::MAX_CAL_SAMPLES;
      end else begin
         n_eff = cal_samples;
      end
      samp_next = {1'b0, samp_ff} + 14'd1;
      out_free  = !rsp_valid_ff || rsp_ready;
      final_frame = !head_item.start && active_ff &&
                    (disc_ff >= imubc_pkg::DISCARD_FRAMES) &&
                    (samp_next >= {1'b0, n_eff});

      for (int i = 0; i < imubc_pkg::AXES; i++) begin
         diff[i] = imubc_pkg::CORR_W'(signed'(head_item.raw[i])) -
                   imubc_pkg::CORR_W'(signed'(offs_ff[i]));
      end
      tprod = imubc_pkg::TPROD_W'(head_item.tmag) * imubc_pkg::TPROD_W'(imubc_pkg::RECIP_17);
      tq    = imubc_pkg::TEMP_W'(tprod[imubc_pkg::TPROD_W-1:imubc_pkg::RECIP_SHIFT]);
      temp  = head_item.tneg ? (imubc_pkg::TEMP_OFFSET - tq) : (imubc_pkg::TEMP_OFFSET + tq);
      qfix  = (axis_ff == imubc_pkg::AXIS_AZ) ? (div_rsp.quotient - imubc_pkg::ACCEL_ONE_G)
                                             : div_rsp.quotient;

      state_in  = state_ff;
      axis_in   = axis_ff;
      sums_in   = sums_ff;
      offs_in   = offs_ff;
      disc_in   = disc_ff;
      samp_in   = samp_ff;
      active_in = active_ff;
      done_in   = done_ff;
      load      = 1'b0;
      div_req.go       = 1'b0;
      div_req.dividend = sums_ff[axis_ff];
      div_req.divisor  = samp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && head_item.start && out_free) begin
               for (int i = 0; i < imubc_pkg::AXES; i++) begin
                  sums_in[i] = '0;
               end
               disc_in   = '0;
               samp_in   = '0;
               active_in = 1'b1;
               load      = 1'b1;
            end else if (head_valid && !head_item.start && active_ff &&
                         (disc_ff >= imubc_pkg::DISCARD_FRAMES)) begin
               // accumulate now; the final frame stays queued until offsets are in
               if (final_frame || out_free) begin
                  for (int i = 0; i < imubc_pkg::AXES; i++) begin
                     sums_in[i] = sums_ff[i] +
                                  imubc_pkg::SUM_W'(signed'(head_item.raw[i]));
                  end
                  samp_in = samp_next[imubc_pkg::CNT_W-1:0];
               end
               if (final_frame) begin
                  axis_in  = '0;
                  state_in = ST_LOAD;
               end else if (out_free) begin
                  load = 1'b1;
               end
            end else if (head_valid && !head_item.start && out_free) begin
               if (active_ff) begin
                  disc_in = disc_ff + 6'd1;
               end
               load = 1'b1;
            end
         end
         ST_LOAD: begin
            div_req.go = 1'b1;
            state_in   = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               offs_in[axis_ff] = qfix;
               if (axis_ff == imubc_pkg::AXIS_LAST) begin
                  active_in = 1'b0;
                  done_in   = 1'b1;
                  state_in  = ST_EMIT;
               end else begin
                  axis_in  = axis_ff + 3'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EMIT: begin
            // the result of the item before may still be waiting
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pop = load;

      result_in = result_ff;
      if (load) begin
         if (head_item.start) begin
            result_in.ax   = '0;
            result_in.ay   = '0;
            result_in.az   = '0;
            result_in.gx   = '0;
            result_in.gy   = '0;
            result_in.gz   = '0;
            result_in.temp = '0;
         end else begin
            result_in.ax   = imubc_pkg::OFF_W'(diff[0]);
            result_in.ay   = imubc_pkg::OFF_W'(diff[1]);
            result_in.az   = diff[2];
            result_in.gx   = imubc_pkg::OFF_W'(diff[3]);
            result_in.gy   = imubc_pkg::OFF_W'(diff[4]);
            result_in.gz   = imubc_pkg::OFF_W'(diff[5]);
            result_in.temp = temp;
         end
         result_in.calibrating = active_in;
         result_in.calibrated  = done_in;
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_valid    = rsp_valid_ff;
      rsp_result   = result_ff;
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      axis_ff   <= axis_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         disc_ff      <= '0;
         samp_ff      <= '0;
         active_ff    <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < imubc_pkg::AXES; i++) begin
            sums_ff[i] <= '0;
            offs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         disc_ff      <= disc_in;
         samp_ff      <= samp_in;
         active_ff    <= active_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff      <= sums_in;
         offs_ff      <= offs_in;
      end
   end

endmodule

### sv/imu_bias_calibrate_correct.sv
// ----------------------------------------------------------------------------
// imu_bias_calibrate_correct
// Bias calibration by averaging and offset correction of six-axis frames.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_     | in        | tuser: mode; tdata: ax, ay, az, gx, gy, gz, temp_raw
//  rsp_     | out       | tuser: calibrating, calibrated; tdata: corrected axes, temp
//  csr_     | in        | cal_samples (13 bits)
//
//  a start command or an ordinary frame passes from the queue to the registered result stage
//  the final calibration frame stays queued while the serial divider runs
//  one quotient bit per cycle for each axis in turn
//  a two-item queue keeps accepting until full while the back end divides or the result waits
//  reset is synchronous; cal_samples returns to 200 and all offsets to zero
// ----------------------------------------------------------------------------
module imu_bias_calibrate_correct (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temp_raw
   input  logic [0:0]   req_tuser,   // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // accel_x_corr, accel_y_corr, accel_z_corr, gyro_x_corr,
                                     // gyro_y_corr, gyro_z_corr, temp_centi, zero pad
   output logic [1:0]   rsp_tuser,   // calibrating, calibrated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [12:0]  csr_data     // cal_samples
);

   logic [imubc_pkg::CNT_W-1:0]  cal_samples_ff, cal_samples_in;
   imubc_pkg::imubc_item_type    front_item;
   imubc_pkg::imubc_item_type    head_item;
   imubc_pkg::imubc_div_req_type div_req;
   imubc_pkg::imubc_div_rsp_type div_rsp;
   imubc_pkg::imubc_result_type  result;
   logic                         q_full;
   logic                         q_push;
   logic                         q_pop;
   logic                         head_valid;

   always_comb begin
      csr_ready      = 1'b1;
      cal_samples_in = (csr_valid && csr_ready) ? csr_data : cal_samples_ff;
      req_tready     = !q_full;
      q_push         = req_tvalid && req_tready;
      rsp_tdata      = {2'b00, result.temp, result.gz, result.gy, result.gx,
                        result.az, result.ay, result.ax};
      rsp_tuser      = {result.calibrated, result.calibrating};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_samples_ff <= imubc_pkg::CAL_SAMPLES_RST;
      end else begin
         cal_samples_ff <= cal_samples_in;
      end
   end

   imubc_front u_front (
      .req_mode (req_tuser[0]),
      .req_raw  (req_tdata[95:0]),
      .req_temp (req_tdata[111:96]),
      .item     (front_item)
   );

   imubc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   imubc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   imubc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cal_samples (cal_samples_ff),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (q_pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result)
   );

endmodule
